FILE: rtl/core/smpc_pkg.sv
package smpc_pkg;

    localparam int ANGLE_W     = 32;
    localparam int CURRENT_W   = 16;
    localparam int WRAP_W      = 10;
    localparam int IDX_W       = 9;
    localparam int CUR_W       = 13;
    localparam int MAG_W       = 15;
    localparam int PROD_W      = CUR_W + MAG_W;
    localparam int DAC_W       = 12;
    localparam int SCALED_W    = 24;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 36;
    localparam int LANES       = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CUR_W-1:0]   CURRENT_LIMIT = 13'd6600;
    localparam logic [WRAP_W-1:0]  EIGHTH_TURN   = 10'd128;
    localparam logic [IDX_W-1:0]   QUARTER_TURN  = 9'd256;
    localparam logic [WRAP_W-1:0]  HALF_TURN     = 10'd512;
    localparam logic [DAC_W-1:0]   DAC_MA_FULL   = 12'd3300;
    localparam logic [PROD_W-1:0]  TABLE_FULL    = 28'd65535;
    localparam logic [RECIP_W-1:0] DAC_RECIP     =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd3300);

    typedef struct packed {
        logic [WRAP_W-1:0] wrapped;
        logic [CUR_W-1:0]  current;
        logic [MAG_W-1:0]  sin_mag;
        logic [MAG_W-1:0]  cos_mag;
        logic              b_dir;
        logic              a_dir;
    } item_t;

    localparam logic [15:0] QUARTER_WAVE [0:256] = '{
        16'd0,16'd402,16'd804,16'd1206,16'd1608,16'd2010,16'd2412,16'd2814,
        16'd3216,16'd3617,16'd4019,16'd4420,16'd4821,16'd5222,16'd5623,16'd6023,
        16'd6424,16'd6824,16'd7223,16'd7623,16'd8022,16'd8421,16'd8820,16'd9218,
        16'd9616,16'd10014,16'd10411,16'd10808,16'd11204,16'd11600,16'd11996,16'd12391,
        16'd12785,16'd13179,16'd13573,16'd13966,16'd14359,16'd14751,16'd15142,16'd15533,
        16'd15924,16'd16313,16'd16703,16'd17091,16'd17479,16'd17866,16'd18253,16'd18639,
        16'd19024,16'd19408,16'd19792,16'd20175,16'd20557,16'd20939,16'd21319,16'd21699,
        16'd22078,16'd22456,16'd22834,16'd23210,16'd23586,16'd23960,16'd24334,16'd24707,
        16'd25079,16'd25450,16'd25820,16'd26189,16'd26557,16'd26925,16'd27291,16'd27656,
        16'd28020,16'd28383,16'd28745,16'd29106,16'd29465,16'd29824,16'd30181,16'd30538,
        16'd30893,16'd31247,16'd31600,16'd31952,16'd32302,16'd32651,16'd32999,16'd33346,
        16'd33692,16'd34036,16'd34379,16'd34721,16'd35061,16'd35400,16'd35738,16'd36074,
        16'd36409,16'd36743,16'd37075,16'd37406,16'd37736,16'd38064,16'd38390,16'd38715,
        16'd39039,16'd39361,16'd39682,16'd40001,16'd40319,16'd40635,16'd40950,16'd41263,
        16'd41575,16'd41885,16'd42194,16'd42500,16'd42806,16'd43109,16'd43411,16'd43712,
        16'd44011,16'd44308,16'd44603,16'd44897,16'd45189,16'd45479,16'd45768,16'd46055,
        16'd46340,16'd46624,16'd46905,16'd47185,16'd47464,16'd47740,16'd48014,16'd48287,
        16'd48558,16'd48827,16'd49095,16'd49360,16'd49624,16'd49885,16'd50145,16'd50403,
        16'd50659,16'd50913,16'd51166,16'd51416,16'd51664,16'd51911,16'd52155,16'd52398,
        16'd52638,16'd52877,16'd53113,16'd53348,16'd53580,16'd53811,16'd54039,16'd54266,
        16'd54490,16'd54713,16'd54933,16'd55151,16'd55367,16'd55582,16'd55794,16'd56003,
        16'd56211,16'd56417,16'd56620,16'd56822,16'd57021,16'd57218,16'd57413,16'd57606,
        16'd57797,16'd57985,16'd58171,16'd58356,16'd58537,16'd58717,16'd58895,16'd59070,
        16'd59243,16'd59414,16'd59582,16'd59749,16'd59913,16'd60075,16'd60234,16'd60391,
        16'd60546,16'd60699,16'd60850,16'd60998,16'd61144,16'd61287,16'd61429,16'd61567,
        16'd61704,16'd61838,16'd61970,16'd62100,16'd62227,16'd62352,16'd62475,16'd62595,
        16'd62713,16'd62829,16'd62942,16'd63053,16'd63161,16'd63267,16'd63371,16'd63472,
        16'd63571,16'd63668,16'd63762,16'd63853,16'd63943,16'd64030,16'd64114,16'd64196,
        16'd64276,16'd64353,16'd64428,16'd64500,16'd64570,16'd64638,16'd64703,16'd64765,
        16'd64826,16'd64883,16'd64939,16'd64992,16'd65042,16'd65090,16'd65136,16'd65179,
        16'd65219,16'd65258,16'd65293,16'd65327,16'd65357,16'd65386,16'd65412,16'd65435,
        16'd65456,16'd65475,16'd65491,16'd65504,16'd65515,16'd65524,16'd65530,16'd65534,
        16'd65535
    };

endpackage

FILE: rtl/core/smpc_front.sv
module smpc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           forward_rotation,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // step_angle [31:0], current_ma [47:32]
    input  logic [smpc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           out_valid,
    input  logic                           out_ready,
    output smpc_pkg::item_t                out_item
);
    import smpc_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    item_t                item_reg;
    item_t                item_next;
    logic [WRAP_W-1:0]    wrapped;
    logic [CURRENT_W-1:0] current_in;
    logic [WRAP_W-1:0]    ang;
    logic [IDX_W-1:0]     half;
    logic [IDX_W-1:0]     sin_idx;
    logic [IDX_W-1:0]     cos_idx;
    logic [15:0]          sin_raw;
    logic [15:0]          cos_raw;
    logic                 sin_neg;
    logic                 cos_neg;

    always_comb
    begin
        wrapped    = s_axis_tdata[WRAP_W-1:0];
        current_in = s_axis_tdata[ANGLE_W +: CURRENT_W];
        ang        = wrapped + EIGHTH_TURN;
        half       = ang[IDX_W-1:0];
        // fold the upper half of each half turn back onto the quarter wave
        sin_idx    = half[IDX_W-1] ? IDX_W'(HALF_TURN - {1'b0, half}) : half;
        cos_idx    = QUARTER_TURN - sin_idx;
        sin_raw    = QUARTER_WAVE[sin_idx];
        cos_raw    = QUARTER_WAVE[cos_idx];
        sin_neg    = ang[WRAP_W-1];
        cos_neg    = (ang[WRAP_W-1] ^ ang[WRAP_W-2]) ^ ~forward_rotation;

        item_next.wrapped = wrapped;
        item_next.current = (current_in > CURRENT_W'(CURRENT_LIMIT)) ? CURRENT_LIMIT
                                                                     : current_in[CUR_W-1:0];
        item_next.sin_mag = sin_raw[15:1];
        item_next.cos_mag = cos_raw[15:1];
        item_next.a_dir   = (sin_raw[15:1] != '0) && !sin_neg;
        item_next.b_dir   = (cos_raw[15:1] != '0) && !cos_neg;
    end

    assign s_axis_tready = !valid_reg || out_ready;
    assign valid_next    = s_axis_tready ? s_axis_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/core/smpc_queue.sv
module smpc_queue #(
    parameter int DEPTH = smpc_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  smpc_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output smpc_pkg::item_t out_item
);
    import smpc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/core/smpc_back.sv
module smpc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  smpc_pkg::item_t                in_item,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // wrapped_angle [9:0], dac_phase_a [21:10], dac_phase_b [33:22],
    // bridge_a_dir [34], bridge_b_dir [35], zero [39:36]
    output logic [smpc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import smpc_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] adv;

    logic [WRAP_W-1:0] w_reg [STAGES];
    logic [1:0]        d_reg [STAGES];

    logic [PROD_W-1:0]   p1_reg [LANES];
    logic [PROD_W-1:0]   p1_next [LANES];
    logic [PROD_W-1:0]   p2_reg [LANES];
    logic [DAC_W-1:0]    q2_reg [LANES];
    logic [DAC_W-1:0]    q2_next [LANES];
    logic [DAC_W-1:0]    x3_reg [LANES];
    logic [DAC_W-1:0]    x3_next [LANES];
    logic [SCALED_W-1:0] n4_reg [LANES];
    logic [SCALED_W-1:0] n4_next [LANES];
    logic [DAC_W-1:0]    q4_reg [LANES];
    logic [DAC_W-1:0]    q4_next [LANES];
    logic [DAC_W-1:0]    dac5_reg [LANES];
    logic [DAC_W-1:0]    dac5_next [LANES];

    logic [MAG_W-1:0]                mag [LANES];
    logic [PROD_W-1:0]               sum2 [LANES];
    logic [PROD_W-1:0]               rem3 [LANES];
    logic [SCALED_W+RECIP_W-1:0]     prod4 [LANES];
    logic [SCALED_W-1:0]             back5 [LANES];
    logic [SCALED_W-1:0]             rem5 [LANES];

    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || m_axis_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next[0] = adv[0] ? in_valid : v_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign in_ready = adv[0];

    always_comb
    begin
        mag[0] = in_item.sin_mag;
        mag[1] = in_item.cos_mag;
        for (int l = 0; l < LANES; l++)
        begin
            // current times magnitude
            p1_next[l] = {{MAG_W{1'b0}}, in_item.current} * {{CUR_W{1'b0}}, mag[l]};
            // divide by 65535: estimate, then one correction
            sum2[l]    = p1_reg[l] + {16'b0, p1_reg[l][PROD_W-1:16]};
            q2_next[l] = sum2[l][PROD_W-1:16];
            rem3[l]    = p2_reg[l] - ({q2_reg[l], 16'b0} - {16'b0, q2_reg[l]});
            x3_next[l] = q2_reg[l] + DAC_W'(rem3[l] >= TABLE_FULL);
            // times 4095 / 3300 through a reciprocal, then one correction
            n4_next[l] = {x3_reg[l], 12'b0} - {12'b0, x3_reg[l]};
            prod4[l]   = {{RECIP_W{1'b0}}, n4_next[l]} * {{SCALED_W{1'b0}}, DAC_RECIP};
            q4_next[l] = prod4[l][RECIP_SHIFT +: DAC_W];
            back5[l]   = {12'b0, q4_reg[l]} * {12'b0, DAC_MA_FULL};
            rem5[l]    = n4_reg[l] - back5[l];
            dac5_next[l] = q4_reg[l] + DAC_W'(rem5[l] >= SCALED_W'(DAC_MA_FULL));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            w_reg[0] <= in_item.wrapped;
            d_reg[0] <= {in_item.b_dir, in_item.a_dir};
            p1_reg   <= p1_next;
        end
        if (adv[1])
        begin
            w_reg[1] <= w_reg[0];
            d_reg[1] <= d_reg[0];
            p2_reg   <= p1_reg;
            q2_reg   <= q2_next;
        end
        if (adv[2])
        begin
            w_reg[2] <= w_reg[1];
            d_reg[2] <= d_reg[1];
            x3_reg   <= x3_next;
        end
        if (adv[3])
        begin
            w_reg[3] <= w_reg[2];
            d_reg[3] <= d_reg[2];
            n4_reg   <= n4_next;
            q4_reg   <= q4_next;
        end
        if (adv[4])
        begin
            w_reg[4] <= w_reg[3];
            d_reg[4] <= d_reg[3];
            dac5_reg <= dac5_next;
        end
    end

    assign m_axis_tvalid = v_reg[STAGES-1];
    assign m_axis_tdata  = {4'b0, d_reg[STAGES-1], dac5_reg[1], dac5_reg[0], w_reg[STAGES-1]};

endmodule

FILE: rtl/core/stepper_microstep_phase_currents_core.sv
// channel   direction  fields (low bit first)
// s_axis    in         step_angle [31:0], current_ma [47:32]
// m_axis    out        wrapped_angle [9:0], dac_phase_a [21:10], dac_phase_b [33:22],
//                      bridge_a_dir [34], bridge_b_dir [35]
// cfg       in         forward_rotation (cfg_wdata, written when cfg_we is high)
//
// one transaction per cycle in and out while m_axis_tready is held high; each item passes
// through the front register, one queue slot, five back stages (two divide-by-constant steps)
// asynchronous active-low reset empties all stages and sets forward_rotation to 1
// an output stall fills the back stages, then the queue of QUEUE_DEPTH entries,
// then the front register, and only then drops s_axis_tready
module stepper_microstep_phase_currents_core #(
    parameter int QUEUE_DEPTH = smpc_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // step_angle [31:0], current_ma [47:32]
    input  logic [smpc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // wrapped_angle [9:0], dac_phase_a [21:10], dac_phase_b [33:22],
    // bridge_a_dir [34], bridge_b_dir [35], zero [39:36]
    output logic [smpc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import smpc_pkg::*;

    logic  fwd_reg;
    logic  fwd_next;
    logic  front_valid;
    logic  front_ready;
    item_t front_item;
    logic  queue_valid;
    logic  queue_ready;
    item_t queue_item;

    assign fwd_next = cfg_we ? cfg_wdata : fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b1;
        end
        else
        begin
            fwd_reg <= fwd_next;
        end
    end

    smpc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .forward_rotation (fwd_reg),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .out_valid        (front_valid),
        .out_ready        (front_ready),
        .out_item         (front_item)
    );

    smpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    smpc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (queue_valid),
        .in_ready      (queue_ready),
        .in_item       (queue_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // largest code with the current limit applied is 4093
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[21:10] <= 12'd4093)
                       && (m_axis_tdata[33:22] <= 12'd4093))
        else $error("dac code above saturated maximum");

    // angle zero sits in the first quadrant after the eighth-turn offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[9:0] == 10'd0))
            |-> (m_axis_tdata[34] && (m_axis_tdata[35] == fwd_reg)))
        else $error("bridge direction wrong at angle zero");

    // angle half turn lands in the third quadrant
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[9:0] == 10'd512))
            |-> (!m_axis_tdata[34] && (m_axis_tdata[35] == !fwd_reg)))
        else $error("bridge direction wrong at half turn");

    assert property (@(posedge clk)
        $past(!rst_n) |-> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule
